// ----- rtl/trrl_pkg.sv -----
// trrl_pkg: shared types and constants for the timestamp ring replay lookup.
// Used by trrl_ctrl, trrl_dp and timestamp_ring_replay_lookup_top.
`timescale 1ns / 1ps

package trrl_pkg;

    localparam int FRAME_DEPTH_DEF = 128;
    localparam int SLOT_W          = 7;
    localparam int TIME_W          = 32;
    localparam int CFG_W           = 16;
    localparam int FRAC_BITS       = 16;
    localparam int DIV_CNT_W       = $clog2(FRAC_BITS);

    localparam logic [CFG_W-1:0] REWIND_RESET = 16'd5000;
    localparam logic [CFG_W-1:0] LINGER_RESET = 16'd750;

    // config register select is paddr[2]
    localparam logic REG_REWIND = 1'b0;
    localparam logic REG_LINGER = 1'b1;

    typedef enum logic [1:0] {
        FN_RECORD = 2'd0,
        FN_START  = 2'd1,
        FN_STEP   = 2'd2,
        FN_NONE   = 2'd3
    } trrl_func_t;

    typedef enum logic [2:0] {
        ST_IGNORED  = 3'd0,
        ST_RECORDED = 3'd1,
        ST_STARTED  = 3'd2,
        ST_FRAME    = 3'd3,
        ST_ENDED    = 3'd4
    } trrl_code_t;

    // which fields the result beat carries
    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_REC,
        OUT_END,
        OUT_FALL,
        OUT_FRAME
    } trrl_sel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_PRIME,
        S_FIRST,
        S_WALK,
        S_DIV,
        S_FRAME
    } trrl_state_t;

    typedef struct packed {
        logic       load_in;
        logic       rec_write;
        logic       arm;
        logic       calc_t;
        logic       clear_active;
        logic       walk_init;
        logic       walk_step;
        logic       first_cap;
        logic       prev_cap;
        logic       div_init;
        logic       div_step;
        logic       emit;
        trrl_sel_t  sel;
        trrl_code_t code;
    } trrl_cmd_t;

    typedef struct packed {
        trrl_func_t func;
        logic       active;
        logic       fill_ge2;
        logic       st_new;
        logic       past_stop;
        logic       found;
        logic       last_entry;
        logic       div_last;
    } trrl_stat_t;

endpackage

// ----- rtl/trrl_ram.sv -----
// trrl_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module trrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/trrl_ctrl.sv -----
// trrl_ctrl: sequencer for record, start and step items.
// Depends on trrl_pkg; drives trrl_dp through trrl_cmd_t.
`timescale 1ns / 1ps

module trrl_ctrl
    import trrl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  trrl_stat_t stat,
    output trrl_cmd_t  cmd
);

    trrl_state_t state_reg;
    trrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.func == FN_STEP && stat.active)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CHECK:
            begin
                if (!stat.fill_ge2 || stat.past_stop)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_PRIME;
                end
            end
            S_PRIME:
            begin
                state_next = S_FIRST;
            end
            S_FIRST:
            begin
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (stat.found)
                begin
                    state_next = S_DIV;
                end
                else if (stat.last_entry)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = S_FRAME;
                end
            end
            S_FRAME:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        cmd.sel  = OUT_NONE;
        cmd.code = ST_IGNORED;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = start;
            end
            S_DECODE:
            begin
                unique case (stat.func)
                    FN_RECORD:
                    begin
                        cmd.emit = 1'b1;
                        if (!stat.active && stat.st_new)
                        begin
                            cmd.rec_write = 1'b1;
                            cmd.sel       = OUT_REC;
                            cmd.code      = ST_RECORDED;
                        end
                    end
                    FN_START:
                    begin
                        cmd.emit = 1'b1;
                        if (stat.fill_ge2)
                        begin
                            cmd.arm  = 1'b1;
                            cmd.code = ST_STARTED;
                        end
                    end
                    FN_STEP:
                    begin
                        if (stat.active)
                        begin
                            cmd.calc_t = 1'b1;
                        end
                        else
                        begin
                            cmd.emit = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.emit = 1'b1;
                    end
                endcase
            end
            S_CHECK:
            begin
                if (!stat.fill_ge2 || stat.past_stop)
                begin
                    cmd.clear_active = 1'b1;
                    cmd.emit         = 1'b1;
                    cmd.sel          = OUT_END;
                    cmd.code         = ST_ENDED;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                end
            end
            S_PRIME:
            begin
                cmd.walk_step = 1'b1;
            end
            S_FIRST:
            begin
                cmd.first_cap = 1'b1;
                cmd.walk_step = 1'b1;
            end
            S_WALK:
            begin
                if (stat.found)
                begin
                    cmd.div_init = 1'b1;
                end
                else if (stat.last_entry)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = OUT_FALL;
                    cmd.code = ST_FRAME;
                end
                else
                begin
                    cmd.prev_cap  = 1'b1;
                    cmd.walk_step = 1'b1;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_FRAME:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = OUT_FRAME;
                cmd.code = ST_FRAME;
            end
            default:
            begin
                cmd.sel = OUT_NONE;
            end
        endcase
    end

endmodule

// ----- rtl/trrl_dp.sv -----
// trrl_dp: timestamp ring, replay window state, bracket walk and fraction divider.
// Depends on trrl_pkg and trrl_ram; commanded by trrl_ctrl.
`timescale 1ns / 1ps

module trrl_dp
    import trrl_pkg::*;
#(
    parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  trrl_cmd_t               cmd,
    output trrl_stat_t              stat,
    input  logic [1:0]              func,
    input  logic signed [TIME_W-1:0] server_time,
    input  logic signed [TIME_W-1:0] kill_time,
    input  logic signed [TIME_W-1:0] now,
    input  logic [CFG_W-1:0]        rewind_ms,
    input  logic [CFG_W-1:0]        linger_ms,
    output logic                    done,
    output logic [2:0]              status,
    output logic [SLOT_W-1:0]       slot_a,
    output logic [SLOT_W-1:0]       slot_b,
    output logic [FRAC_BITS-1:0]    fraction,
    output logic signed [TIME_W-1:0] playback_time,
    output logic                    replaying
);

    localparam int AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int CW = $clog2(FRAME_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(FRAME_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(FRAME_DEPTH);

    // latched item
    logic [1:0]        func_reg;
    logic [TIME_W-1:0] st_reg;
    logic [TIME_W-1:0] kt_reg;
    logic [TIME_W-1:0] now_reg;

    // ring and replay state
    logic [AW-1:0]     write_slot_reg;
    logic [CW-1:0]     fill_reg;
    logic [TIME_W-1:0] last_rec_reg;
    logic              active_reg;
    logic [TIME_W-1:0] win_start_reg;
    logic [TIME_W-1:0] win_stop_reg;
    logic [TIME_W-1:0] start_clock_reg;

    // walk
    logic [TIME_W-1:0] t_reg;
    logic [AW-1:0]     rd_slot_reg;
    logic [CW-1:0]     rd_cnt_reg;
    logic [AW-1:0]     data_slot_reg;
    logic [CW-1:0]     data_cnt_reg;
    logic [TIME_W-1:0] first_val_reg;
    logic [AW-1:0]     first_slot_reg;
    logic [TIME_W-1:0] prev_val_reg;
    logic [AW-1:0]     prev_slot_reg;
    logic [AW-1:0]     a_reg;
    logic [AW-1:0]     b_reg;

    // divider
    logic [TIME_W-1:0]    rem_reg;
    logic [TIME_W-1:0]    den_reg;
    logic [FRAC_BITS-1:0] q_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;

    // result beat
    logic                 done_reg;
    logic [2:0]           status_reg;
    logic [SLOT_W-1:0]    slot_a_reg;
    logic [SLOT_W-1:0]    slot_b_reg;
    logic [FRAC_BITS-1:0] fraction_reg;
    logic [TIME_W-1:0]    ptime_reg;
    logic                 replaying_reg;

    logic [TIME_W-1:0] rd_data;
    logic [CW-1:0]     ws_ext;
    logic [AW-1:0]     oldest_slot;
    logic [TIME_W-1:0] t_next;
    logic [TIME_W:0]   rem2;
    logic              rem_ge;
    logic [AW-1:0]     res_sa;
    logic [AW-1:0]     res_sb;
    logic [FRAC_BITS-1:0] res_frac;
    logic [TIME_W-1:0] res_ptime;
    logic              replaying_next;
    logic [AW+SLOT_W-1:0] sa_wide;
    logic [AW+SLOT_W-1:0] sb_wide;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
        slot_inc = (s == LAST_SLOT) ? '0 : s + AW'(1);
    endfunction

    trrl_ram #(
        .WIDTH (TIME_W),
        .DEPTH (FRAME_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.rec_write),
        .waddr (write_slot_reg),
        .wdata (st_reg),
        .re    (cmd.walk_step),
        .raddr (rd_slot_reg),
        .rdata (rd_data)
    );

    // oldest = (write_slot - fill) mod depth
    assign ws_ext = CW'(write_slot_reg);
    always_comb
    begin
        logic [CW-1:0] diff;
        diff = (ws_ext >= fill_reg) ? (ws_ext - fill_reg) : (DEPTH_C - fill_reg + ws_ext);
        oldest_slot = diff[AW-1:0];
    end

    assign t_next = win_start_reg + (now_reg - start_clock_reg);

    assign rem2   = {rem_reg, 1'b0};
    assign rem_ge = (rem2 >= {1'b0, den_reg});

    assign stat.func       = trrl_func_t'(func_reg);
    assign stat.active     = active_reg;
    assign stat.fill_ge2   = (fill_reg >= CW'(2));
    assign stat.st_new     = (st_reg != last_rec_reg);
    assign stat.past_stop  = ($signed(t_reg) >= $signed(win_stop_reg));
    assign stat.found      = ($signed(prev_val_reg) <= $signed(t_reg))
                             && ($signed(t_reg) < $signed(rd_data));
    assign stat.last_entry = (data_cnt_reg == fill_reg - CW'(1));
    assign stat.div_last   = (dcnt_reg == DIV_CNT_W'(FRAC_BITS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= func;
            st_reg   <= server_time;
            kt_reg   <= kill_time;
            now_reg  <= now;
        end
        if (cmd.calc_t)
        begin
            t_reg <= t_next;
        end
        if (cmd.walk_init)
        begin
            rd_slot_reg <= oldest_slot;
            rd_cnt_reg  <= '0;
        end
        else if (cmd.walk_step)
        begin
            rd_slot_reg <= slot_inc(rd_slot_reg);
            rd_cnt_reg  <= rd_cnt_reg + CW'(1);
        end
        if (cmd.walk_step)
        begin
            data_slot_reg <= rd_slot_reg;
            data_cnt_reg  <= rd_cnt_reg;
        end
        if (cmd.first_cap)
        begin
            first_val_reg  <= rd_data;
            first_slot_reg <= data_slot_reg;
        end
        if (cmd.first_cap || cmd.prev_cap)
        begin
            prev_val_reg  <= rd_data;
            prev_slot_reg <= data_slot_reg;
        end
        if (cmd.div_init)
        begin
            a_reg    <= prev_slot_reg;
            b_reg    <= data_slot_reg;
            rem_reg  <= t_reg - prev_val_reg;
            den_reg  <= rd_data - prev_val_reg;
            q_reg    <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? TIME_W'(rem2 - {1'b0, den_reg}) : rem2[TIME_W-1:0];
            q_reg    <= {q_reg[FRAC_BITS-2:0], rem_ge};
            dcnt_reg <= dcnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg  <= '0;
            fill_reg        <= '0;
            last_rec_reg    <= '0;
            active_reg      <= 1'b0;
            win_start_reg   <= '0;
            win_stop_reg    <= '0;
            start_clock_reg <= '0;
        end
        else
        begin
            if (cmd.rec_write)
            begin
                last_rec_reg   <= st_reg;
                write_slot_reg <= slot_inc(write_slot_reg);
                if (fill_reg != DEPTH_C)
                begin
                    fill_reg <= fill_reg + CW'(1);
                end
            end
            if (cmd.arm)
            begin
                active_reg      <= 1'b1;
                win_start_reg   <= kt_reg - TIME_W'(rewind_ms);
                win_stop_reg    <= kt_reg + TIME_W'(linger_ms);
                start_clock_reg <= now_reg;
            end
            else if (cmd.clear_active)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    // result fields
    always_comb
    begin
        res_sa    = '0;
        res_sb    = '0;
        res_frac  = '0;
        res_ptime = '0;
        unique case (cmd.sel)
            OUT_NONE:
            begin
                res_sa = '0;
            end
            OUT_REC:
            begin
                res_sa = write_slot_reg;
            end
            OUT_END:
            begin
                res_ptime = t_reg;
            end
            OUT_FALL:
            begin
                // no bracketing pair: clamp to oldest or newest frame
                res_sa    = ($signed(t_reg) < $signed(first_val_reg)) ? first_slot_reg
                                                                       : data_slot_reg;
                res_sb    = res_sa;
                res_ptime = t_reg;
            end
            OUT_FRAME:
            begin
                res_sa    = a_reg;
                res_sb    = b_reg;
                res_frac  = q_reg;
                res_ptime = t_reg;
            end
            default:
            begin
                res_sa = '0;
            end
        endcase
    end

    assign replaying_next = cmd.arm ? 1'b1 : (cmd.clear_active ? 1'b0 : active_reg);
    assign sa_wide = {{SLOT_W{1'b0}}, res_sa};
    assign sb_wide = {{SLOT_W{1'b0}}, res_sb};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg    <= cmd.code;
            slot_a_reg    <= sa_wide[SLOT_W-1:0];
            slot_b_reg    <= sb_wide[SLOT_W-1:0];
            fraction_reg  <= res_frac;
            ptime_reg     <= res_ptime;
            replaying_reg <= replaying_next;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign slot_a        = slot_a_reg;
    assign slot_b        = slot_b_reg;
    assign fraction      = fraction_reg;
    assign playback_time = ptime_reg;
    assign replaying     = replaying_reg;

endmodule

// ----- rtl/timestamp_ring_replay_lookup_top.sv -----
// Timestamp ring replay lookup, top level: APB register file, controller, datapath.
// A record, start or ignored item is answered from decode; a step is answered from the check when
// replay ends, from the walk with no bracketing pair, and after the divider with one
// (ring walk at one entry per cycle, 16-step divider).
// Next item is accepted at the edge that takes the done beat; the receiver cannot stall.
// rst_n is asynchronous active low; ring contents are not cleared, so no clearing pass is needed.
`timescale 1ns / 1ps

module timestamp_ring_replay_lookup_top
    import trrl_pkg::*;
#(
    parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               func,
    input  logic signed [TIME_W-1:0] server_time,
    input  logic signed [TIME_W-1:0] kill_time,
    input  logic signed [TIME_W-1:0] now,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output logic                     done,
    output logic [2:0]               status,
    output logic [SLOT_W-1:0]        slot_a,
    output logic [SLOT_W-1:0]        slot_b,
    output logic [FRAC_BITS-1:0]     fraction,
    output logic signed [TIME_W-1:0] playback_time,
    output logic                     replaying
);

    logic [CFG_W-1:0] rewind_reg;
    logic [CFG_W-1:0] linger_reg;
    logic             cfg_wr;
    trrl_cmd_t        cmd;
    trrl_stat_t       stat;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rewind_reg <= REWIND_RESET;
            linger_reg <= LINGER_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_REWIND:
                begin
                    rewind_reg <= pwdata[CFG_W-1:0];
                end
                REG_LINGER:
                begin
                    linger_reg <= pwdata[CFG_W-1:0];
                end
                default:
                begin
                    rewind_reg <= rewind_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_REWIND:
            begin
                prdata = {16'b0, rewind_reg};
            end
            REG_LINGER:
            begin
                prdata = {16'b0, linger_reg};
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    trrl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    trrl_dp #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .func          (func),
        .server_time   (server_time),
        .kill_time     (kill_time),
        .now           (now),
        .rewind_ms     (rewind_reg),
        .linger_ms     (linger_reg),
        .done          (done),
        .status        (status),
        .slot_a        (slot_a),
        .slot_b        (slot_b),
        .fraction      (fraction),
        .playback_time (playback_time),
        .replaying     (replaying)
    );

endmodule
